// ===== hdl/scanline_dark_run_regions_top_defines.svh =====
// Assertion macros shared by the scanline dark run region checker
`ifndef SCANLINE_DARK_RUN_REGIONS_TOP_DEFINES_SVH
`define SCANLINE_DARK_RUN_REGIONS_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is low
`define SDRR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is low
`define SDRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset
`define SDRR_ASSERT_RAW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sdrr_pkg.sv =====
// Package: widths, register indexes, types and reset values of the dark run finder
`default_nettype none

package sdrr_pkg;

    // Field widths
    localparam int PixelW   = 8;
    localparam int CoordW   = 12;
    localparam int OutW     = 16;
    localparam int HeightW  = 6;
    localparam int IndexW   = 10;
    localparam int LightW   = 7;
    localparam int CountW   = 11;
    localparam int InDataW  = 32;
    localparam int OutDataW = 64;

    // Configuration port
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 13;

    localparam logic [CfgAddrW-1:0] REG_IMAGE_HEIGHT = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_X_SCALE      = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_Y_SCALE      = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_GAP_LENGTH   = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_REGION_LIMIT = 3'd4;

    // Reset values
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd512;
    localparam logic [4:0]  RST_X_SCALE      = 5'd1;
    localparam logic [4:0]  RST_Y_SCALE      = 5'd1;
    localparam logic [6:0]  RST_GAP_LENGTH   = 7'd60;
    localparam logic [10:0] RST_REGION_LIMIT = 11'd1024;

    localparam int MAX_REGIONS_DEF = 1024;

    // Light counter saturates here
    localparam logic [LightW-1:0] LIGHT_MAX = 7'd127;

    // Tallest region in rows before scaling
    localparam logic [1:0] HEIGHT_CAP = 2'd2;

    typedef struct packed {
        logic [12:0] image_height;
        logic [4:0]  x_scale;
        logic [4:0]  y_scale;
        logic [6:0]  gap_length;
        logic [10:0] region_limit;
    } t_cfg;

    // Packed so that region_x lands in the lowest bits
    typedef struct packed {
        logic [IndexW-1:0]  region_index;
        logic [HeightW-1:0] region_height;
        logic [OutW-1:0]    region_width;
        logic [OutW-1:0]    region_y;
        logic [OutW-1:0]    region_x;
    } t_region;

endpackage

`default_nettype wire

// ===== hdl/sdrr_scale.sv =====
// Region scaler: turns a closed run into a scaled rectangle
`default_nettype none

module sdrr_scale (
    input  wire logic [sdrr_pkg::CoordW-1:0] i_run_first,
    input  wire logic [sdrr_pkg::CoordW-1:0] i_run_last,
    input  wire logic [sdrr_pkg::CoordW-1:0] i_row,
    input  wire sdrr_pkg::t_cfg              i_cfg,
    input  wire logic [sdrr_pkg::CountW-1:0] i_index,
    output sdrr_pkg::t_region                o_region
);

    logic [sdrr_pkg::CoordW-1:0]   diff;
    logic [sdrr_pkg::CoordW:0]     rows_left;
    logic [1:0]                    rows;
    logic [sdrr_pkg::CoordW+4:0]   x_prod;
    logic [sdrr_pkg::CoordW+4:0]   y_prod;
    logic [sdrr_pkg::CoordW+4:0]   w_prod;
    logic [6:0]                    h_prod;

    // Width wraps within the column range
    assign diff = i_run_last - i_run_first;

    // Rows left in the image, clamped to two, zero past the bottom
    assign rows_left = i_cfg.image_height - {1'b0, i_row};
    always_comb begin
        if (i_cfg.image_height <= {1'b0, i_row}) begin
            rows = 2'd0;
        end else if (rows_left >= {11'd0, sdrr_pkg::HEIGHT_CAP}) begin
            rows = sdrr_pkg::HEIGHT_CAP;
        end else begin
            rows = rows_left[1:0];
        end
    end

    // Small multiplies, results cut to the field widths
    assign x_prod = {5'd0, i_run_first} * {12'd0, i_cfg.x_scale};
    assign y_prod = {5'd0, i_row} * {12'd0, i_cfg.y_scale};
    assign w_prod = {5'd0, diff} * {12'd0, i_cfg.x_scale};
    assign h_prod = {5'd0, rows} * {2'd0, i_cfg.y_scale};

    always_comb begin
        o_region.region_x      = x_prod[sdrr_pkg::OutW-1:0];
        o_region.region_y      = y_prod[sdrr_pkg::OutW-1:0];
        o_region.region_width  = w_prod[sdrr_pkg::OutW-1:0];
        o_region.region_height = h_prod[sdrr_pkg::HeightW-1:0];
        o_region.region_index  = i_index[sdrr_pkg::IndexW-1:0];
    end

endmodule

`default_nettype wire

// ===== hdl/scanline_dark_run_regions_top.sv =====
// Top level: dark run region finder over a raster pixel stream
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: pixel, column, row; tlast: end_of_row
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: x, y, width, height, index
//   cfg       in   i_cfg_we                     i_cfg_addr, i_cfg_wdata
//
// One pixel per clock while m_axis is not stalled. A pixel is first held in the input
// register, then the run tracker and scaler fill the result register, from which a region
// shows on m_axis. Reset (synchronous, active low) clears the run state, counters, both
// valid flags and loads the register defaults. A stall on m_axis freezes the tracker; one
// more pixel can still enter the input register.
`default_nettype none

module scanline_dark_run_regions_top #(
    parameter int MAX_REGIONS = sdrr_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] pixel, [19:8] column, [31:20] row
    input  wire logic [sdrr_pkg::InDataW-1:0]    s_axis_tdata,
    // end_of_row
    input  wire logic                            s_axis_tlast,

    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [15:0] region_x, [31:16] region_y, [47:32] region_width,
    // [53:48] region_height, [63:54] region_index
    output logic [sdrr_pkg::OutDataW-1:0]        m_axis_tdata,

    input  wire logic                            i_cfg_we,
    input  wire logic [sdrr_pkg::CfgAddrW-1:0]   i_cfg_addr,
    input  wire logic [sdrr_pkg::CfgDataW-1:0]   i_cfg_wdata
);

    sdrr_pkg::t_cfg                  r_cfg;

    logic                            r_in_valid;
    logic [sdrr_pkg::PixelW-1:0]     r_in_pixel;
    logic [sdrr_pkg::CoordW-1:0]     r_in_col;
    logic [sdrr_pkg::CoordW-1:0]     r_in_row;
    logic                            r_in_eor;

    logic [sdrr_pkg::CoordW-1:0]     r_run_first, n_run_first;
    logic [sdrr_pkg::CoordW-1:0]     r_run_last,  n_run_last;
    logic                            r_run_open,  n_run_open;
    logic [sdrr_pkg::LightW-1:0]     r_light,     n_light;
    logic [sdrr_pkg::CountW-1:0]     r_emitted,   n_emitted;

    logic                            r_out_valid;
    sdrr_pkg::t_region               r_out_data;

    logic                            advance;
    logic                            process;
    logic                            limit_ok;
    logic                            emit;
    logic [sdrr_pkg::LightW-1:0]     light_inc;
    sdrr_pkg::t_region               region;

    // Pipeline flow: result register frees when empty or taken
    assign advance       = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height <= sdrr_pkg::RST_IMAGE_HEIGHT;
            r_cfg.x_scale      <= sdrr_pkg::RST_X_SCALE;
            r_cfg.y_scale      <= sdrr_pkg::RST_Y_SCALE;
            r_cfg.gap_length   <= sdrr_pkg::RST_GAP_LENGTH;
            r_cfg.region_limit <= sdrr_pkg::RST_REGION_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sdrr_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_wdata;
                sdrr_pkg::REG_X_SCALE:      r_cfg.x_scale      <= i_cfg_wdata[4:0];
                sdrr_pkg::REG_Y_SCALE:      r_cfg.y_scale      <= i_cfg_wdata[4:0];
                sdrr_pkg::REG_GAP_LENGTH:   r_cfg.gap_length   <= i_cfg_wdata[6:0];
                sdrr_pkg::REG_REGION_LIMIT: r_cfg.region_limit <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_pixel <= s_axis_tdata[7:0];
            r_in_col   <= s_axis_tdata[19:8];
            r_in_row   <= s_axis_tdata[31:20];
            r_in_eor   <= s_axis_tlast;
        end
    end

    // Emission allowed below min(region_limit, MAX_REGIONS)
    assign limit_ok = (r_emitted < r_cfg.region_limit)
                   && ({21'd0, r_emitted} < 32'(MAX_REGIONS));

    assign light_inc = (r_light == sdrr_pkg::LIGHT_MAX) ? r_light : r_light + 7'd1;

    // Run tracker
    always_comb begin
        n_run_first = r_run_first;
        n_run_last  = r_run_last;
        n_run_open  = r_run_open;
        n_light     = r_light;
        emit        = 1'b0;
        if (r_in_pixel == '0) begin
            if (!r_run_open) begin
                n_run_first = r_in_col;
                n_run_open  = 1'b1;
            end
            n_run_last = r_in_col;
            n_light    = '0;
        end else if (r_run_open) begin
            n_light = light_inc;
            if (light_inc >= r_cfg.gap_length && limit_ok) begin
                emit       = 1'b1;
                n_run_open = 1'b0;
                n_light    = '0;
            end
        end
        // Row end closes any open run
        if (r_in_eor) begin
            if (n_run_open && limit_ok) begin
                emit = 1'b1;
            end
            n_run_open = 1'b0;
            n_light    = '0;
        end
        n_emitted = r_emitted + {10'd0, emit};
    end

    sdrr_scale u_scale (
        .i_run_first (n_run_first),
        .i_run_last  (n_run_last),
        .i_row       (r_in_row),
        .i_cfg       (r_cfg),
        .i_index     (r_emitted),
        .o_region    (region)
    );

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_first <= '0;
            r_run_last  <= '0;
            r_run_open  <= 1'b0;
            r_light     <= '0;
            r_emitted   <= '0;
        end else if (process) begin
            r_run_first <= n_run_first;
            r_run_last  <= n_run_last;
            r_run_open  <= n_run_open;
            r_light     <= n_light;
            r_emitted   <= n_emitted;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= process && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && emit) begin
            r_out_data <= region;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== hdl/sdrr_checker.sv =====
// Port-level checker for the dark run region finder, bound to the top level
`default_nettype none
`include "scanline_dark_run_regions_top_defines.svh"

module sdrr_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tready,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [sdrr_pkg::OutDataW-1:0] m_axis_tdata
);

    // Result offered but not taken
    logic stalled;
    assign stalled = m_axis_tvalid && !m_axis_tready;

    // Input back-pressure only comes from a stalled result
    `SDRR_ASSERT_IMPL(a_ready, !s_axis_tready, stalled, "s_axis_tready low without output stall")

    // A stalled result holds its transaction
    `SDRR_ASSERT_NEXT(a_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata), "result moved")

    // An offered result carries known data
    `SDRR_ASSERT_IMPL(a_data_known, m_axis_tvalid, !$isunknown(m_axis_tdata), "unknown data")

    // No result right after reset
    `SDRR_ASSERT_RAW(a_reset_quiet, !i_rst_n, !m_axis_tvalid, "result valid after reset")

endmodule

bind scanline_dark_run_regions_top sdrr_checker u_sdrr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
